// ===== rtl/lhm_pkg.sv =====
// shared types and constants of the latency histogram monitor
package lhm_pkg;

  localparam int NUM_BUCKETS = 24;
  localparam int EDGE_COUNT  = 23;
  // bounds that take part in the search: the first NUM_BUCKETS-1 of the defined ones
  localparam int CMP_N       = (NUM_BUCKETS - 1 < EDGE_COUNT) ? NUM_BUCKETS - 1 : EDGE_COUNT;
  localparam int BUCKET_W    = $clog2(NUM_BUCKETS);

  localparam int TS_W        = 64;
  localparam int CNT_W       = 32;
  localparam int IDX_W       = 5;
  localparam int DIV_STEPS   = TS_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int IN_DATA_W   = 128;
  localparam int OUT_DATA_W  = 168;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_NS = 1'd1;

  // upper bounds of the buckets in ns, lo < v <= hi
  localparam logic [TS_W-1:0] BUCKET_HI [EDGE_COUNT] = '{
    64'd1000, 64'd2000, 64'd4000, 64'd8000, 64'd16000, 64'd64000, 64'd128000,
    64'd256000, 64'd512000, 64'd1000000, 64'd2000000, 64'd8000000, 64'd16000000,
    64'd500000000, 64'd1000000000, 64'd2000000000, 64'd4000000000,
    64'd8000000000, 64'd30000000000, 64'd60000000000, 64'd120000000000,
    64'd240000000000, 64'd480000000000
  };

  typedef struct packed {
    logic load_in;
    logic calc_delay;
    logic calc_bin;
    logic calc_idx;
    logic calc_cnt;
    logic div_step;
    logic load_out;
  } lhm_cmd_t;

  typedef struct packed {
    logic need_avg;
    logic div_last;
    logic out_free;
  } lhm_sts_t;

endpackage

// ===== rtl/lhm_ctrl.sv =====
// sequencing state machine of the latency histogram monitor
module lhm_ctrl import lhm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  lhm_sts_t sts,
  output lhm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELAY = 3'd1;
  localparam logic [2:0] S_BIN   = 3'd2;
  localparam logic [2:0] S_IDX   = 3'd3;
  localparam logic [2:0] S_CNT   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) state_nxt = S_DELAY;
      end
      S_DELAY: begin
        cmd.calc_delay = 1'b1;
        state_nxt      = S_BIN;
      end
      S_BIN: begin
        cmd.calc_bin = 1'b1;
        state_nxt    = S_IDX;
      end
      S_IDX: begin
        cmd.calc_idx = 1'b1;
        state_nxt    = S_CNT;
      end
      S_CNT: begin
        // also primes the divider with the updated total and count
        cmd.calc_cnt = 1'b1;
        state_nxt    = sts.need_avg ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.load_out = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lhm_datapath.sv =====
// statistics registers, bucket counters, divider and output register
module lhm_datapath import lhm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  input  lhm_cmd_t              cmd,
  output lhm_sts_t              sts
);

  logic                cfg_en_r;
  logic [TS_W-1:0]     cfg_int_r;
  logic [TS_W-1:0]     start_r;
  logic [TS_W-1:0]     end_r;
  logic [TS_W-1:0]     delay_r;
  logic [CMP_N-1:0]    le_r;
  logic [TS_W-1:0]     total_r;
  logic [CNT_W-1:0]    count_r;
  logic [TS_W-1:0]     last_log_r;
  logic [TS_W-1:0]     diff_r;
  logic                ge_r;
  logic [BUCKET_W-1:0] idx_r;
  logic                need_r;
  logic [CNT_W-1:0]    bucket_cnt_r [NUM_BUCKETS];
  logic [CNT_W-1:0]    cnt_out_r;
  logic [TS_W-1:0]     quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                out_user_r;

  logic [TS_W:0]       sum;
  logic [BUCKET_W-1:0] idx_enc;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_sub;
  logic [TS_W-1:0]     avg;

  assign sum = {1'b0, total_r} + {1'b0, delay_r};

  // lowest bound that holds the delay, last bucket otherwise
  always_comb begin
    idx_enc = BUCKET_W'(NUM_BUCKETS - 1);
    for (int i = CMP_N - 1; i >= 0; i--) begin
      if (le_r[i]) idx_enc = BUCKET_W'(i);
    end
  end

  assign cur_cnt   = bucket_cnt_r[idx_r];
  assign new_cnt   = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);
  assign trial     = {rem_r, quo_r[TS_W-1]};
  assign trial_sub = trial - {1'b0, count_r};
  assign avg       = need_r ? quo_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r  <= 1'b0;
      cfg_int_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INTERVAL_EN: cfg_en_r  <= cfg_wdata[0];
        REG_INTERVAL_NS: cfg_int_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item pipeline of the sequencer
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      start_r <= in_tdata[TS_W-1:0];
      end_r   <= in_tdata[2*TS_W-1:TS_W];
    end
    if (cmd.calc_delay) begin
      delay_r <= (end_r >= start_r) ? end_r - start_r : '0;
    end
    if (cmd.calc_bin) begin
      for (int i = 0; i < CMP_N; i++) begin
        le_r[i] <= (delay_r <= BUCKET_HI[i]);
      end
      diff_r <= end_r - last_log_r;
      ge_r   <= (end_r >= last_log_r);
    end
    if (cmd.calc_idx) begin
      idx_r  <= idx_enc;
      need_r <= cfg_en_r && (last_log_r != '0) && ge_r && (diff_r > cfg_int_r);
    end
    if (cmd.calc_cnt) begin
      cnt_out_r <= new_cnt;
      quo_r     <= total_r;
      rem_r     <= '0;
      step_r    <= '0;
    end else if (cmd.div_step) begin
      // restoring divide, one quotient bit per cycle
      if (!trial_sub[CNT_W]) begin
        rem_r <= trial_sub[CNT_W-1:0];
        quo_r <= {quo_r[TS_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[CNT_W-1:0];
        quo_r <= {quo_r[TS_W-2:0], 1'b0};
      end
      step_r <= step_r + STEP_W'(1);
    end
  end

  // running statistics, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      count_r    <= '0;
      last_log_r <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bucket_cnt_r[i] <= '0;
      end
    end else begin
      if (cmd.calc_bin) begin
        total_r <= sum[TS_W] ? '1 : sum[TS_W-1:0];
        if (count_r != '1) count_r <= count_r + CNT_W'(1);
      end
      if (cmd.calc_idx && cfg_en_r && (last_log_r == '0)) begin
        last_log_r <= end_r;
      end
      if (cmd.calc_cnt) begin
        bucket_cnt_r[idx_r] <= new_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {3'b000, avg, cnt_out_r, IDX_W'(idx_r), delay_r};
      out_user_r <= need_r;
    end
  end

  assign sts.need_avg = need_r;
  assign sts.div_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/latency_histogram_monitor_core.sv =====
// Latency histogram monitor: each request carries a start and an end time in ns; the block
// returns the delay, its log-style bucket and that bucket's new saturating count. With interval
// checking on, the first request sets the last-log time and later requests ending more than
// interval_ns past it also return the average delay (total / count). A result is loaded into
// the output register after the request passes the delay, bucket, index and count states,
// and also the divider when an average is returned: a restoring divider yielding one quotient
// bit per cycle for the 64-bit total. The next request is taken in the cycle after the load;
// only one request is in work at a time, and a stalled output holds back the load. A finished
// result sits in an output register, so the next request is taken while it waits.
module latency_histogram_monitor_core import lhm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_ns, end_ns
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // delay_ns, bucket_index, bucket_count, avg_ns, pad
  output logic                  out_tuser   // avg_valid
);

  lhm_cmd_t cmd;
  lhm_sts_t sts;

  lhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lhm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/lhm_checker.sv =====
// port-level checks of the latency histogram monitor
module lhm_checker import lhm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in work");

  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[164:101] == 64'd0)
    else $error("average present without avg_valid");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[68:64] < IDX_W'(NUM_BUCKETS) && out_tdata[100:69] != 32'd0)
    else $error("bucket index out of range or count not advanced");

endmodule

bind latency_histogram_monitor_core lhm_checker u_lhm_checker (.*);
